// ===== hdl/prts_pkg.sv =====
package prts_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_START  = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NONE    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  task_priority;
    logic [15:0] slice_length;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] task_id;
    logic       switch_request;
    logic       running;
  } res_t;

endpackage

// ===== hdl/prts_pick.sv =====
// Highest occupied priority ring.
module prts_pick #(
  parameter int LEVELS = 4,
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic [LEVELS-1:0] occupied,
  output logic              found,
  output logic [LW-1:0]     level
);

  always_comb begin
    found = 1'b0;
    level = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (occupied[i]) begin
        found = 1'b1;
        level = LW'(i);
      end
    end
  end

endmodule

// ===== hdl/priority_ring_time_slice_scheduler.sv =====
// Task scheduler with one circular ring of tasks per priority level. Each
// command beat (create, start, tick) gives exactly one result beat. Beats
// go through an input register and a result register with single-pass logic
// over small register-held task tables in between, so one beat is taken
// every cycle unless res_stall holds a pending result; each result beat is
// registered from its command in the input register. A ring keeps forward
// links only; the successor of a ring's tail is read from that ring's head.
module priority_ring_time_slice_scheduler
  import prts_pkg::*;
#(
  parameter int TASK_SLOTS      = 8,
  parameter int PRIORITY_LEVELS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);

  // input register
  logic s1_valid;
  cmd_t s1;

  // task tables
  logic [IW-1:0] next_link [TASK_SLOTS];
  logic [PW-1:0] slot_prio [TASK_SLOTS];
  logic [15:0]   slice_remaining [TASK_SLOTS];
  logic [15:0]   slice_reload [TASK_SLOTS];
  logic [IW-1:0] ring_head [PRIORITY_LEVELS];
  logic [IW-1:0] ring_tail [PRIORITY_LEVELS];

  logic [PRIORITY_LEVELS-1:0] ring_occupied, ring_occupied_next;
  logic [CW-1:0] tasks_created, tasks_created_next;
  logic [IW-1:0] current_id, current_id_next;
  logic          started, started_next;
  res_t          res_next;

  logic          adv, do_item;
  logic          prio_ok, full;
  logic [PW-1:0] prio_idx, cur_prio, rd_prio, pick_level;
  logic          pick_found;
  logic [IW-1:0] new_id, head_rd, tail_rd, nxt;
  logic [15:0]   rem_dec;
  logic          rem_we, cr_we, link_we, head_we, tail_we;
  logic [IW-1:0] rem_addr;
  logic [15:0]   rem_wdata;

  prts_pick #(.LEVELS(PRIORITY_LEVELS)) u_pick (
    .occupied (ring_occupied),
    .found    (pick_found),
    .level    (pick_level)
  );

  assign adv       = !res_valid || !res_stall;
  assign do_item   = s1_valid && adv;
  assign cmd_stall = s1_valid && !adv;

  assign prio_idx = PW'(s1.task_priority);
  assign prio_ok  = 32'(s1.task_priority) < PRIORITY_LEVELS;
  assign full     = tasks_created >= CW'(TASK_SLOTS);
  assign new_id   = tasks_created[IW-1:0];
  assign cur_prio = slot_prio[current_id];
  assign rem_dec  = slice_remaining[current_id] - 16'd1;

  // one ring-end read port shared by the three commands
  always_comb begin
    case (s1.op)
      OP_CREATE: rd_prio = prio_idx;
      OP_START:  rd_prio = pick_level;
      default:   rd_prio = cur_prio;
    endcase
  end

  assign head_rd = ring_head[rd_prio];
  assign tail_rd = ring_tail[rd_prio];
  assign nxt     = (current_id == tail_rd) ? head_rd : next_link[current_id];

  always_comb begin
    started_next       = started;
    current_id_next    = current_id;
    tasks_created_next = tasks_created;
    ring_occupied_next = ring_occupied;
    rem_we    = 1'b0;
    rem_addr  = current_id;
    rem_wdata = rem_dec;
    cr_we     = 1'b0;
    link_we   = 1'b0;
    head_we   = 1'b0;
    tail_we   = 1'b0;
    res_next.status         = ST_IGNORED;
    res_next.task_id        = 3'(current_id);
    res_next.switch_request = 1'b0;
    case (s1.op)
      OP_CREATE: begin
        res_next.task_id = '0;
        if (prio_ok && full) begin
          res_next.status = ST_FULL;
        end else if (prio_ok) begin
          res_next.status    = ST_OK;
          res_next.task_id   = 3'(new_id);
          tasks_created_next = tasks_created + CW'(1);
          cr_we     = 1'b1;
          rem_we    = 1'b1;
          rem_addr  = new_id;
          rem_wdata = s1.slice_length;
          tail_we   = 1'b1;
          if (!ring_occupied[prio_idx]) begin
            head_we = 1'b1;
            ring_occupied_next[prio_idx] = 1'b1;
          end else begin
            link_we = 1'b1;
          end
        end
      end
      OP_START: begin
        if (!started && pick_found) begin
          started_next     = 1'b1;
          current_id_next  = head_rd;
          res_next.status  = ST_OK;
          res_next.task_id = 3'(head_rd);
        end else if (!started) begin
          res_next.status  = ST_NONE;
          res_next.task_id = '0;
        end
      end
      OP_TICK: begin
        if (!started) begin
          res_next.task_id = '0;
        end else begin
          rem_we = 1'b1;
          res_next.status = ST_OK;
          if (rem_dec == 16'd0) begin
            // slice used up: reload it and move along the ring
            rem_wdata       = slice_reload[current_id];
            current_id_next = nxt;
            res_next.switch_request = nxt != current_id;
          end
          res_next.task_id = 3'(current_id_next);
        end
      end
      default: ;
    endcase
    res_next.running = started_next;
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      s1 <= cmd;
    end
    if (do_item) begin
      res <= res_next;
      if (rem_we) begin
        slice_remaining[rem_addr] <= rem_wdata;
      end
      if (cr_we) begin
        slice_reload[new_id] <= s1.slice_length;
        slot_prio[new_id]    <= prio_idx;
      end
      if (link_we) begin
        next_link[tail_rd] <= new_id;
      end
      if (head_we) begin
        ring_head[prio_idx] <= new_id;
      end
      if (tail_we) begin
        ring_tail[prio_idx] <= new_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      res_valid     <= 1'b0;
      ring_occupied <= '0;
      tasks_created <= '0;
      current_id    <= '0;
      started       <= 1'b0;
    end else begin
      if (!cmd_stall) begin
        s1_valid <= cmd_valid;
      end
      if (adv) begin
        res_valid <= s1_valid;
      end
      if (do_item) begin
        ring_occupied <= ring_occupied_next;
        tasks_created <= tasks_created_next;
        current_id    <= current_id_next;
        started       <= started_next;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tasks_created <= CW'(TASK_SLOTS))
    else $error("task count beyond table size");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_FULL |-> tasks_created == CW'(TASK_SLOTS))
    else $error("table full reported with free slots");

  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.switch_request |-> res.status == ST_OK && res.running)
    else $error("switch request outside a running tick");

  a_started_holds: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("scheduling stopped after start");

endmodule
